// ----- sv/sha256_pkg.sv -----
package sha256_pkg;

    localparam int unsigned NUM_ROUNDS = 64;
    localparam int unsigned NUM_WORDS  = 8;
    localparam int unsigned W_BYTES    = 64;
    localparam int unsigned LEN_OFFSET = 56;

    typedef logic [31:0] t_word;

    typedef enum logic {
        KIND_ABSORB = 1'b0,
        KIND_FINISH = 1'b1
    } t_kind;

    typedef struct packed {
        logic  kind;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        t_word      digest_word;
        logic [2:0] word_index;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_core_ctl;

    function automatic t_word round_k(input logic [5:0] idx);
        t_word k;
        unique case (idx)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic t_word init_hash(input logic variant, input logic [2:0] idx);
        t_word h;
        unique case ({variant, idx})
            4'h0: h = 32'h6a09e667; 4'h1: h = 32'hbb67ae85; 4'h2: h = 32'h3c6ef372;
            4'h3: h = 32'ha54ff53a; 4'h4: h = 32'h510e527f; 4'h5: h = 32'h9b05688c;
            4'h6: h = 32'h1f83d9ab; 4'h7: h = 32'h5be0cd19; 4'h8: h = 32'hc1059ed8;
            4'h9: h = 32'h367cd507; 4'ha: h = 32'h3070dd17; 4'hb: h = 32'hf70e5939;
            4'hc: h = 32'hffc00b31; 4'hd: h = 32'h68581511; 4'he: h = 32'h64f98fa7;
            default: h = 32'hbefa4fa4;
        endcase
        return h;
    endfunction

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ----- sv/sha256_if.sv -----
interface sha256_in_if;
    import sha256_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface sha256_out_if;
    import sha256_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- sv/sha256_round.sv -----
module sha256_round (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sha256_pkg::t_core_ctl i_ctl,
    input  sha256_pkg::t_word     i_wr_word,
    input  logic [3:0]            i_wr_idx,
    input  logic                  i_wr_en,
    input  sha256_pkg::t_word     i_chain [8],
    output sha256_pkg::t_word     o_sum [8],
    output logic                  o_done
);
    import sha256_pkg::*;

    t_word      r_w [16];
    t_word      r_v [8];
    logic [5:0] r_round;
    logic       r_run;
    logic       r_done;

    t_word s0, s1, w_new, w_cur, t1, t2, e_s, a_s, ch, mj;

    always_comb begin
        s0    = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1    = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = s1 + r_w[9] + s0 + r_w[0];
        w_cur = r_w[0];
        e_s   = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        a_s   = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        mj    = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1    = r_v[7] + e_s + ch + round_k(r_round) + w_cur;
        t2    = a_s + mj;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_done  <= 1'b0;
            r_round <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_run   <= 1'b1;
                r_round <= '0;
            end else if (r_run) begin
                r_round <= r_round + 6'd1;
                if (r_round == 6'(NUM_ROUNDS - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_w[i_wr_idx] <= i_wr_word;
        end else if (r_run) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_new;
        end
        if (i_ctl.start) begin
            for (int i = 0; i < 8; i++) r_v[i] <= i_chain[i];
        end else if (r_run) begin
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) o_sum[i] = i_chain[i] + r_v[i];
    end
    assign o_done = r_done;

    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run && r_round == 6'd63 && !i_ctl.start) |=> r_done)
        else $error("done missing after last round");
    a_no_start_while_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> !i_ctl.start)
        else $error("start while running");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_run)
        else $error("done while running");
endmodule

// ----- sv/sha256_hash_engine_top.sv -----
// Channel | Dir | Payload                           | Handshake
// in      | in  | kind, data_byte                   | valid/ready
// out     | out | digest_word, word_index, last     | valid/ready
// cfg     | in  | variant                           | i_cfg_we, no wait
// An absorb transaction is taken while idle; the 64th byte of a block starts the
// shared round unit (one round per cycle, then chain update).
// A finish transaction pads one byte per cycle up to byte 55, writes the length as two
// words and runs one compression; a 0x80 past byte 55 first pads out and compresses an
// extra block. Then 7 or 8 words out, one per accepted cycle.
// Reset is synchronous, active low, and loads the SHA-256 initial value.
// Input ready is low while padding, compressing or delivering words; output stalls hold.
module sha256_hash_engine_top (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata,
    sha256_in_if.sink    in_if,
    sha256_out_if.source out_if
);
    import sha256_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_PAD, ST_LEN, ST_RUN, ST_UPD, ST_OUT
    } t_state;

    t_state     r_state;
    t_word      r_chain [8];
    logic [5:0] r_fill;
    logic [60:0] r_bytes;
    logic       r_variant;
    logic       r_fin;
    logic       r_second;
    logic [2:0] r_oidx;
    logic [3:0] r_widx;
    t_word      r_acc;

    t_core_ctl  ctl;
    t_word      sum [8];
    logic       done;
    t_word      wr_word;
    logic       wr_en;
    logic [63:0] bit_len;

    assign bit_len = {r_bytes, 3'b000};
    assign in_if.ready = (r_state == ST_IDLE);

    sha256_round u_round (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl),
        .i_wr_word(wr_word), .i_wr_idx(r_widx), .i_wr_en(wr_en),
        .i_chain(r_chain), .o_sum(sum), .o_done(done)
    );

    logic acc_in;
    logic [7:0] pad_byte;
    assign acc_in = in_if.valid && in_if.ready;

    always_comb begin
        pad_byte = 8'h00;
        if (r_state == ST_IDLE) pad_byte = in_if.payload.data_byte;
        else if (r_state == ST_PAD && r_fin) pad_byte = 8'h80;
        wr_word = {r_acc[23:0], pad_byte};
        wr_en   = 1'b0;
        if (r_fill[1:0] == 2'd3) begin
            if (r_state == ST_IDLE) wr_en = acc_in && in_if.payload.kind == KIND_ABSORB;
            if (r_state == ST_PAD)  wr_en = 1'b1;
        end
        if (r_state == ST_LEN) begin
            wr_en   = 1'b1;
            wr_word = r_fill[2] ? bit_len[31:0] : bit_len[63:32];
        end
        ctl.start = (r_state == ST_LEN && r_fill[2]) ||
                    (r_state == ST_PAD && r_fill == 6'd63) ||
                    (r_state == ST_IDLE && wr_en && r_fill == 6'd63);
        ctl.busy  = (r_state == ST_RUN);
        ctl.done  = done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_fill    <= '0;
            r_widx    <= '0;
            r_bytes   <= '0;
            r_variant <= 1'b0;
            r_fin     <= 1'b0;
            r_second  <= 1'b0;
            r_oidx    <= '0;
            out_if.valid <= 1'b0;
            for (int i = 0; i < 8; i++) r_chain[i] <= init_hash(1'b0, 3'(i));
        end else begin
            if (r_state == ST_PAD || (acc_in && in_if.payload.kind == KIND_ABSORB)) begin
                r_acc <= wr_word;
            end
            if (r_state == ST_LEN || wr_en) r_widx <= r_widx + 4'd1;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cfg_we) begin
                        r_variant <= i_cfg_wdata;
                        r_fill    <= '0;
                        r_widx    <= '0;
                        r_bytes   <= '0;
                        for (int i = 0; i < 8; i++) r_chain[i] <= init_hash(i_cfg_wdata, 3'(i));
                    end else if (acc_in) begin
                        if (in_if.payload.kind == KIND_ABSORB) begin
                            r_fill  <= r_fill + 6'd1;
                            r_bytes <= r_bytes + 61'd1;
                            if (r_fill == 6'd63) r_state <= ST_RUN;
                        end else begin
                            r_fin    <= 1'b1;
                            r_second <= 1'b0;
                            r_state  <= ST_PAD;
                        end
                    end
                end
                ST_PAD: begin
                    r_fin  <= 1'b0;
                    r_fill <= r_fill + 6'd1;
                    if (r_fill == 6'd63) r_state <= ST_RUN;
                    else if (r_fill == 6'(LEN_OFFSET - 1)) r_state <= ST_LEN;
                end
                ST_LEN: begin
                    r_fill <= r_fill + 6'd4;
                    if (r_fill[2]) begin
                        r_second <= 1'b1;
                        r_state  <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (done) r_state <= ST_UPD;
                end
                ST_UPD: begin
                    for (int i = 0; i < 8; i++) r_chain[i] <= sum[i];
                    r_fill <= '0;
                    r_widx <= '0;
                    if (r_second) begin
                        r_state <= ST_OUT;
                        r_oidx  <= '0;
                        out_if.valid <= 1'b1;
                    end else if (r_fin) begin
                        r_fin   <= 1'b0;
                        r_state <= ST_PAD;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_OUT: begin
                    if (out_if.ready) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (out_if.payload.last) begin
                            out_if.valid <= 1'b0;
                            r_state <= ST_IDLE;
                            r_bytes <= '0;
                            r_second <= 1'b0;
                            for (int i = 0; i < 8; i++) r_chain[i] <= init_hash(r_variant, 3'(i));
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            if (r_state == ST_PAD && r_fill == 6'd63) r_fin <= 1'b1;
        end
    end

    always_comb begin
        out_if.payload.digest_word = r_chain[r_oidx];
        out_if.payload.word_index  = r_oidx;
        out_if.payload.last        = (r_oidx == (r_variant ? 3'd6 : 3'd7));
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_if.valid |-> !in_if.ready)
        else $error("input open while delivering");
    a_start_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.start |=> r_state == ST_RUN)
        else $error("compression not running after start");
    a_out_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_if.valid && out_if.ready && !out_if.payload.last) |=>
        r_oidx == $past(r_oidx) + 3'd1)
        else $error("word index skipped");
endmodule

// ----- dv/sha256_hash_engine_checker.sv -----
`timescale 1ns / 1ps
module sha256_hash_engine_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_cfg_we,
    input  logic  i_cfg_wdata,
    sha256_in_if.sink  in_mon,
    sha256_out_if.sink out_mon,
    output int    o_errors,
    output int    o_pending,
    output int    o_digests
);
    import sha256_pkg::*;

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    localparam logic [31:0] IV_TAB [2][8] = '{
        '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
          32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19},
        '{32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
          32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4}};

    logic        sha224_mode;
    logic [31:0] hash_state [8];
    logic [7:0]  block_buf [64];
    int          block_fill;
    logic [63:0] msg_bits;
    t_out_item   digest_q [$];

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
            w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        v = hash_state;
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] = hash_state[i] + v[i];
        block_fill = 0;
    endtask

    task automatic restart_hash();
        hash_state = IV_TAB[sha224_mode];
        block_fill = 0;
        msg_bits   = '0;
    endtask

    task automatic finish_message();
        t_out_item it;
        int        n;
        block_buf[block_fill] = 8'h80;
        block_fill++;
        if (block_fill > 56) begin
            for (int i = block_fill; i < 64; i++)
                block_buf[i] = 8'h00;
            compress_block();
        end
        for (int i = block_fill; i < 56; i++)
            block_buf[i] = 8'h00;
        for (int i = 0; i < 8; i++)
            block_buf[56+i] = msg_bits[63-8*i -: 8];
        compress_block();
        n = sha224_mode ? 7 : 8;
        for (int i = 0; i < n; i++) begin
            it.digest_word = hash_state[i];
            it.word_index  = 3'(i);
            it.last        = (i == n - 1);
            digest_q.push_back(it);
        end
        restart_hash();
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            sha224_mode = 1'b0;
            restart_hash();
            digest_q.delete();
        end else begin
            if (i_cfg_we) begin
                sha224_mode = i_cfg_wdata;
                restart_hash();
            end
            if (out_mon.valid && out_mon.ready) begin
                if (digest_q.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected word expected none actual %h/%0d/%0d", $time,
                             out_mon.payload.digest_word, out_mon.payload.word_index,
                             out_mon.payload.last);
                end else begin
                    want = digest_q.pop_front();
                    if (want != out_mon.payload) begin
                        o_errors++;
                        $display("%0t: mismatch expected %h/%0d/%0d actual %h/%0d/%0d", $time,
                                 want.digest_word, want.word_index, want.last,
                                 out_mon.payload.digest_word, out_mon.payload.word_index,
                                 out_mon.payload.last);
                    end
                    if (want.last)
                        o_digests++;
                end
            end
            if (in_mon.valid && in_mon.ready) begin
                if (in_mon.payload.kind == KIND_FINISH) begin
                    finish_message();
                end else begin
                    block_buf[block_fill] = in_mon.payload.data_byte;
                    block_fill++;
                    msg_bits += 64'd8;
                    if (block_fill == 64)
                        compress_block();
                end
            end
        end
        o_pending = digest_q.size();
    end
endmodule

// ----- dv/tb_sha256_hash_engine_top.sv -----
`timescale 1ns / 1ps
module tb_sha256_hash_engine_top;
    import sha256_pkg::*;

    localparam int STALL_LIMIT = 5000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_wdata = 1'b0;
    int   errors, pending, digests;
    int   idle_cycles = 0;
    int   bytes_sent = 0;
    bit   calm = 1'b0;

    sha256_in_if  in_if();
    sha256_out_if out_if();

    sha256_hash_engine_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .in_if(in_if.sink), .out_if(out_if.source)
    );

    sha256_hash_engine_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .in_mon(in_if.sink), .out_mon(out_if.sink),
        .o_errors(errors), .o_pending(pending), .o_digests(digests)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        in_if.valid   = 1'b0;
        in_if.payload = '0;
        out_if.ready  = 1'b0;
    end

    // stall the sink in random bursts
    initial begin
        int gap;
        @(negedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                out_if.ready <= 1'b0;
                gap = $urandom_range(1, 14);
                repeat (gap) @(negedge i_clk);
            end
            out_if.ready <= 1'b1;
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_item(t_kind kind, logic [7:0] data);
        if (!calm && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        in_if.valid             = 1'b1;
        in_if.payload.kind      = kind;
        in_if.payload.data_byte = data;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        in_if.valid = 1'b0;
        if (kind == KIND_ABSORB)
            bytes_sent++;
    endtask

    task automatic send_message(int len, bit pattern);
        for (int i = 0; i < len; i++)
            send_item(KIND_ABSORB, pattern ? 8'(i * 37 + 5) : 8'($urandom_range(0, 255)));
        send_item(KIND_FINISH, 8'($urandom_range(0, 255)));
    endtask

    task automatic set_variant(logic v);
        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int len;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // empty, one byte of each extreme, second pad block boundaries
        send_message(0, 1'b0);
        send_item(KIND_ABSORB, 8'h00);
        send_item(KIND_ABSORB, 8'hff);
        send_item(KIND_FINISH, 8'hff);
        send_message(3, 1'b1);
        send_message(55, 1'b1);
        send_message(56, 1'b1);
        set_variant(1'b1);
        send_message(0, 1'b0);
        send_message(64, 1'b1);
        // drop a partial message with a variant write
        send_item(KIND_ABSORB, 8'h5a);
        set_variant(1'b1);
        send_message(63, 1'b0);
        set_variant(1'b0);
        for (int p = 0; p < 2; p++) begin
            for (int m = 0; m < 2; m++) begin
                case ($urandom_range(0, 3))
                    0: len = $urandom_range(0, 8);
                    1: len = $urandom_range(52, 60);
                    2: len = $urandom_range(62, 66);
                    default: len = $urandom_range(0, 130);
                endcase
                send_message(len, 1'b0);
            end
            if (p == 1)
                calm = 1'b1;
            set_variant(1'($urandom_range(0, 1)));
        end
        set_variant(1'b0);
        send_message($urandom_range(0, 40), 1'b0);
        set_variant(1'b1);
        send_message($urandom_range(0, 40), 1'b0);
        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        $display("Covered %0d message bytes over %0d digests in both variants,", bytes_sent,
                 digests);
        $display("including empty messages, pad-block boundaries and mid-message restarts.");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
